[design/xcorr_peak_itd_estimator_defines.svh]
// assertion macros shared by the checker of the itd estimator
// depends on: nothing; users supply clk and rst_n in scope
`ifndef XCORR_PEAK_ITD_ESTIMATOR_DEFINES_SVH
`define XCORR_PEAK_ITD_ESTIMATOR_DEFINES_SVH

// checked only while out of reset
`define XITD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define XITD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/xitd_pkg.sv]
// shared types and fixed field widths of the itd estimator
// depends on: nothing
`default_nettype none
package xitd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int PROD_W   = 32;
  localparam int DELAY_W  = 9;
  localparam int IDX_W    = 10;
  localparam int PEAK_W   = 39;

  localparam logic [DELAY_W-1:0] MAX_LAG_RESET = 9'd31;
  localparam logic [63:0]        PEAK_SAT      = (64'd1 << PEAK_W) - 64'd1;

  // per-beat flags that travel down the multiply-accumulate pipe
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
    logic fin;
  } tag_t;

endpackage
`default_nettype wire

[design/xitd_ram.sv]
// generic single-write, single-read ram with registered read data
// depends on: nothing
`default_nettype none
module xitd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[design/xitd_ctrl.sv]
// sequencer: loads sample pairs, then walks every lag and every product index
// depends on: xitd_pkg
`default_nettype none
module xitd_ctrl #(
  parameter int MAX_LENGTH = 512
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic                                  in_is_last,
  input  wire logic                                  out_busy,
  input  wire logic                                  fin_seen,
  output logic                                       wr_en,
  output logic [$clog2(MAX_LENGTH)-1:0]              wr_addr,
  output logic [$clog2(MAX_LENGTH)-1:0]              rd_addr_l,
  output logic [$clog2(MAX_LENGTH)-1:0]              rd_addr_r,
  output xitd_pkg::tag_t                             iss,
  output logic [$clog2(MAX_LENGTH+1):0]              iss_k,
  output logic                                       start,
  output logic                                       load_out,
  output logic [$clog2(MAX_LENGTH+1)-1:0]            len
);
  import xitd_pkg::*;

  localparam int AW = $clog2(MAX_LENGTH);
  localparam int CW = $clog2(MAX_LENGTH + 1);
  localparam int KW = CW + 1;
  localparam logic [CW-1:0] FULL = CW'(MAX_LENGTH);

  typedef enum logic [3:0] {
    ST_LOAD   = 4'b0001,
    ST_CORR   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_FINISH = 4'b1000
  } st_t;

  st_t           state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [KW-1:0] kmax_r, kmax_nxt;
  logic [AW-1:0] la0_r, la0_nxt;
  logic [AW-1:0] ra0_r, ra0_nxt;
  logic [AW-1:0] la_r, la_nxt;
  logic [AW-1:0] ra_r, ra_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic [CW-1:0] n_r, n_nxt;

  logic          accept;
  logic          room;
  logic [CW-1:0] cnt_inc;
  logic [CW-1:0] len_m1;
  logic          last_el;
  logic          k_end;
  logic          up_side;

  assign in_ready  = (state_r == ST_LOAD);
  assign accept    = in_valid && in_ready;
  assign room      = (cnt_r < FULL);
  assign cnt_inc   = room ? cnt_r + CW'(1) : cnt_r;
  assign len_m1    = cnt_inc - CW'(1);
  assign wr_en     = accept && room;
  assign wr_addr   = cnt_r[AW-1:0];
  assign rd_addr_l = la_r;
  assign rd_addr_r = ra_r;
  assign iss_k     = k_r;
  assign len       = len_r;

  assign last_el = (CW'(i_r) == n_r - CW'(1));
  assign k_end   = (k_r == kmax_r);
  // lags below the center: the right window slides down and grows
  assign up_side = (k_r < KW'(len_r) - KW'(1));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    len_nxt   = len_r;
    k_nxt     = k_r;
    kmax_nxt  = kmax_r;
    la0_nxt   = la0_r;
    ra0_nxt   = ra0_r;
    la_nxt    = la_r;
    ra_nxt    = ra_r;
    i_nxt     = i_r;
    n_nxt     = n_r;
    iss       = '0;
    start     = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        if (accept) begin
          cnt_nxt = cnt_inc;
          if (in_is_last) begin
            cnt_nxt   = '0;
            len_nxt   = cnt_inc;
            state_nxt = ST_CORR;
            k_nxt     = '0;
            kmax_nxt  = (KW'(cnt_inc) << 1) - KW'(2);
            la0_nxt   = '0;
            ra0_nxt   = len_m1[AW-1:0];
            la_nxt    = '0;
            ra_nxt    = len_m1[AW-1:0];
            i_nxt     = '0;
            n_nxt     = CW'(1);
            start     = 1'b1;
          end
        end
      end
      ST_CORR: begin
        iss.vld   = 1'b1;
        iss.first = (i_r == '0);
        iss.last  = last_el;
        iss.fin   = last_el && k_end;
        if (last_el) begin
          if (k_end) begin
            state_nxt = ST_DRAIN;
          end else begin
            k_nxt = k_r + KW'(1);
            i_nxt = '0;
            if (up_side) begin
              ra0_nxt = ra0_r - AW'(1);
              n_nxt   = n_r + CW'(1);
            end else begin
              la0_nxt = la0_r + AW'(1);
              n_nxt   = n_r - CW'(1);
            end
            la_nxt = la0_nxt;
            ra_nxt = ra0_nxt;
          end
        end else begin
          i_nxt  = i_r + AW'(1);
          la_nxt = la_r + AW'(1);
          ra_nxt = ra_r + AW'(1);
        end
      end
      ST_DRAIN: begin
        if (fin_seen) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_busy) begin
          load_out  = 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    k_r    <= k_nxt;
    kmax_r <= kmax_nxt;
    la0_r  <= la0_nxt;
    ra0_r  <= ra0_nxt;
    la_r   <= la_nxt;
    ra_r   <= ra_nxt;
    i_r    <= i_nxt;
    n_r    <= n_nxt;
  end

endmodule
`default_nettype wire

[design/xitd_mac.sv]
// multiply-accumulate pipe and running peak search over finished lags
// depends on: xitd_pkg
`default_nettype none
module xitd_mac #(
  parameter int MAX_LENGTH = 512
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire xitd_pkg::tag_t                              iss,
  input  wire logic [$clog2(MAX_LENGTH+1):0]               iss_k,
  input  wire logic [xitd_pkg::SAMPLE_W-1:0]               l_data,
  input  wire logic [xitd_pkg::SAMPLE_W-1:0]               r_data,
  input  wire logic                                        start,
  output logic                                             fin_seen,
  output logic signed [$clog2(MAX_LENGTH)+32:0]            best_val,
  output logic [$clog2(MAX_LENGTH+1):0]                    best_idx
);
  import xitd_pkg::*;

  localparam int AW    = $clog2(MAX_LENGTH);
  localparam int KW    = $clog2(MAX_LENGTH + 1) + 1;
  localparam int ACC_W = AW + 33;

  tag_t                     s1_r, s2_r, s3_r;
  logic [KW-1:0]            k1_r, k2_r, k3_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic signed [ACC_W-1:0]  best_r;
  logic [KW-1:0]            bidx_r;
  logic signed [SAMPLE_W-1:0] ls, rs;

  assign ls = l_data;
  assign rs = r_data;

  // first product of a lag restarts the sum
  assign acc_nxt = s2_r.first ? ACC_W'(prod_r) : acc_r + ACC_W'(prod_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
      s3_r <= '0;
    end else begin
      s1_r <= iss;
      s2_r <= s1_r;
      s3_r <= s2_r;
    end
  end

  always_ff @(posedge clk) begin
    k1_r   <= iss_k;
    k2_r   <= k1_r;
    k3_r   <= k2_r;
    prod_r <= PROD_W'(ls) * PROD_W'(rs);
    if (s2_r.vld) begin
      acc_r <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r <= '0;
      bidx_r <= '0;
    end else if (start) begin
      best_r <= '0;
      bidx_r <= '0;
    end else if (s3_r.vld && s3_r.last && (acc_r > best_r)) begin
      best_r <= acc_r;
      bidx_r <= k3_r;
    end
  end

  assign fin_seen = s3_r.vld && s3_r.fin;
  assign best_val = best_r;
  assign best_idx = bidx_r;

endmodule
`default_nettype wire

[design/xcorr_peak_itd_estimator.sv]
// Cross-correlation peak ITD estimator, top level.
// Input channel (in_valid/in_ready): one left/right Q1.15 sample pair per beat,
// in_is_last marks the final pair of a response. Pairs beyond MAX_LENGTH are
// dropped; the final pair still closes the response.
// Output channel (out_valid/out_ready): one beat per response carrying the
// left/right delay in samples, the index of the first strict correlation peak
// and its saturated Q9.30 value (index and value 0 when nothing is positive).
// After the final pair the block forms all 2L-1 lags with one product per cycle,
// bound by the single read port of each sample memory; the products then pass
// the multiply-accumulate pipe and result formatting before the result appears.
// in_ready is low from the final pair until the result is loaded.
// cfg_we/cfg_wdata write max_lag (clamp on the delay); write it
// only while the block is idle.
// Reset clears the pair count, the output beat and sets max_lag to 31; the
// sample memories are not cleared and need no clearing pass.
// A stalled result is held in the output register while the next response
// loads; a second result waits until the first one is taken.
// depends on: xitd_pkg, xitd_ram, xitd_ctrl, xitd_mac
`default_nettype none
module xcorr_peak_itd_estimator #(
  parameter int MAX_LENGTH = 512
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_we,
  input  wire logic [xitd_pkg::DELAY_W-1:0]         cfg_wdata,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic signed [xitd_pkg::SAMPLE_W-1:0] in_left_sample,
  input  wire logic signed [xitd_pkg::SAMPLE_W-1:0] in_right_sample,
  input  wire logic                                 in_is_last,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [xitd_pkg::DELAY_W-1:0]              out_left_delay,
  output logic [xitd_pkg::DELAY_W-1:0]              out_right_delay,
  output logic [xitd_pkg::IDX_W-1:0]                out_peak_index,
  output logic [xitd_pkg::PEAK_W-1:0]               out_peak_value
);
  import xitd_pkg::*;

  localparam int AW    = $clog2(MAX_LENGTH);
  localparam int CW    = $clog2(MAX_LENGTH + 1);
  localparam int KW    = CW + 1;
  localparam int ACC_W = AW + 33;
  localparam int MW    = (KW > DELAY_W) ? KW : DELAY_W;

  logic                    wr_en;
  logic [AW-1:0]           wr_addr, rd_addr_l, rd_addr_r;
  logic [SAMPLE_W-1:0]     l_data, r_data;
  tag_t                    iss;
  logic [KW-1:0]           iss_k;
  logic                    start, load_out, fin_seen, out_busy;
  logic [CW-1:0]           len;
  logic signed [ACC_W-1:0] best_val;
  logic [KW-1:0]           best_idx;

  logic [DELAY_W-1:0]      max_lag_r;
  logic                    out_valid_r;
  logic [DELAY_W-1:0]      ld_r, rd_r, ld_nxt, rd_nxt;
  logic [IDX_W-1:0]        pidx_r;
  logic [PEAK_W-1:0]       pval_r, pval_nxt;

  logic [KW-1:0]           center;
  logic                    right_side;
  logic [KW-1:0]           mag;
  logic [MW-1:0]           mag_w, lim_w, clamped;
  logic [63:0]             best_u;

  assign out_busy = out_valid_r && !out_ready;

  xitd_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_LENGTH)) u_left_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (in_left_sample),
    .raddr (rd_addr_l),
    .rdata (l_data)
  );

  xitd_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_LENGTH)) u_right_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (in_right_sample),
    .raddr (rd_addr_r),
    .rdata (r_data)
  );

  xitd_ctrl #(.MAX_LENGTH(MAX_LENGTH)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_is_last (in_is_last),
    .out_busy   (out_busy),
    .fin_seen   (fin_seen),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .rd_addr_l  (rd_addr_l),
    .rd_addr_r  (rd_addr_r),
    .iss        (iss),
    .iss_k      (iss_k),
    .start      (start),
    .load_out   (load_out),
    .len        (len)
  );

  xitd_mac #(.MAX_LENGTH(MAX_LENGTH)) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .iss      (iss),
    .iss_k    (iss_k),
    .l_data   (l_data),
    .r_data   (r_data),
    .start    (start),
    .fin_seen (fin_seen),
    .best_val (best_val),
    .best_idx (best_idx)
  );

  // lag = (L-1) - index; index at or below the center delays the right ear
  assign center     = KW'(len) - KW'(1);
  assign right_side = (best_idx <= center);
  assign mag        = right_side ? center - best_idx : best_idx - center;
  assign mag_w      = MW'(mag);
  assign lim_w      = MW'(max_lag_r);
  assign clamped    = (mag_w > lim_w) ? lim_w : mag_w;
  assign ld_nxt     = right_side ? '0 : clamped[DELAY_W-1:0];
  assign rd_nxt     = right_side ? clamped[DELAY_W-1:0] : '0;

  // peak is never negative, so a zero extension is exact
  assign best_u   = 64'($unsigned(best_val));
  assign pval_nxt = (best_u > PEAK_SAT) ? PEAK_SAT[PEAK_W-1:0] : best_u[PEAK_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_lag_r   <= MAX_LAG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_lag_r <= cfg_wdata;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      ld_r   <= ld_nxt;
      rd_r   <= rd_nxt;
      pidx_r <= IDX_W'(best_idx);
      pval_r <= pval_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_left_delay  = ld_r;
  assign out_right_delay = rd_r;
  assign out_peak_index  = pidx_r;
  assign out_peak_value  = pval_r;

endmodule
`default_nettype wire

[design/xitd_checker.sv]
// port-level checks of the itd estimator, bound to the top level
// depends on: xitd_pkg, xcorr_peak_itd_estimator_defines.svh
`default_nettype none
`include "xcorr_peak_itd_estimator_defines.svh"
module xitd_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_ready,
  input wire logic                          in_is_last,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [xitd_pkg::DELAY_W-1:0]  out_left_delay,
  input wire logic [xitd_pkg::DELAY_W-1:0]  out_right_delay,
  input wire logic [xitd_pkg::IDX_W-1:0]    out_peak_index,
  input wire logic [xitd_pkg::PEAK_W-1:0]   out_peak_value
);
  import xitd_pkg::*;

  // a stalled result beat holds
  `XITD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_peak_index) && $stable(out_peak_value), "stalled result changed")

  // only one ear is ever delayed
  `XITD_ASSERT(a_one_side, out_valid |-> (out_left_delay == '0) || (out_right_delay == '0), "both delays nonzero")

  // no positive correlation means index 0
  `XITD_ASSERT(a_zero_peak, out_valid && (out_peak_value == '0) |-> (out_peak_index == '0), "zero peak with nonzero index")

  // the final beat starts the correlation pass and closes the input
  `XITD_ASSERT(a_last_busy, in_valid && in_ready && in_is_last |=> !in_ready, "input open after final beat")

  // reset drops any pending result
  `XITD_ASSERT_ALWAYS(a_rst_out, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind xcorr_peak_itd_estimator xitd_checker u_xitd_checker (.*);
`default_nettype wire
